// File: rtl/gbe_pkg.sv
// Package: shared constants, tables and word types of the gradient ray box endpoints block.
package gbe_pkg;

    // parameter defaults
    localparam int FRAC_BITS_DEF      = 4;
    localparam int TRIG_FRAC_BITS_DEF = 16;

    // Q1.30 arithmetic
    localparam int          Q30_SHIFT = 30;
    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;

    // angle handling, 1/16 degree units
    localparam logic [12:0] QUARTER   = 13'd1440;
    localparam logic [12:0] HALF_TURN = 13'd2880;
    localparam logic [12:0] THREE_Q   = 13'd4320;
    localparam logic [12:0] FULL_TURN = 13'd5760;

    // quadrant codes
    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // offset to radians: x = round(a * PI_Q30 / 2880), split into quotient and remainder parts
    localparam longint unsigned PI_Q30    = 64'd3373259426;
    localparam int              RAD_DIV   = 2880;
    localparam logic [20:0]     PI_QUOT   = 21'(PI_Q30 / RAD_DIV);
    localparam logic [10:0]     PI_REM    = 11'(PI_Q30 % RAD_DIV);
    localparam logic [10:0]     RAD_RND   = 11'd1440;
    localparam logic [11:0]     RAD_DIV_W = 12'd2880;
    localparam int              LO_SHIFT  = 22;
    localparam logic [10:0]     LO_RECIP  = 11'((64'd1 << LO_SHIFT) / RAD_DIV);

    // Horner divisors, inside out
    localparam int N_SIN = 5;
    localparam int N_COS = 6;
    localparam int SIN_DIV [N_SIN] = '{110, 72, 42, 20, 6};
    localparam int COS_DIV [N_COS] = '{132, 90, 56, 30, 12, 2};

    // channel words
    typedef struct packed {
        logic [12:0] angle_sixteenths;
        logic [11:0] box_width;
        logic [11:0] box_height;
    } t_in;

    typedef struct packed {
        logic [15:0] start_x;
        logic [15:0] start_y;
        logic [15:0] end_x;
        logic [15:0] end_y;
        logic        degenerate;
    } t_out;

endpackage

// File: rtl/gbe_stream_if.sv
// Interface: valid/ready stream channel carrying one word.
interface gbe_stream_if #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/gbe_horner_cell.sv
// Horner cell: one step t' = 1 - ((x2*t)>>30)/DIV, clamped at 0, over three stages.
module gbe_horner_cell #(
    parameter int DIV = 2
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [31:0] i_x2,
    input  logic [30:0] i_t,
    output logic [31:0] o_x2,
    output logic [30:0] o_t
);

    // reciprocal, exact to within one for any 32-bit dividend
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / DIV);
    localparam logic [31:0] DIV_W = 32'(DIV);

    logic [62:0] prod;
    logic [63:0] est;
    logic [31:0] qd;
    logic [31:0] rem;
    logic [31:0] quo;

    logic [31:0] r_p1, r_x2a;
    logic [31:0] r_qe, r_p2, r_x2b;
    logic [30:0] r_t;
    logic [31:0] r_x2c;
    logic [31:0] n_p1;
    logic [31:0] n_qe;
    logic [30:0] n_t;

    // stage 1: product and drop of 30 fraction bits
    assign prod = 63'(i_x2) * 63'(i_t);
    assign n_p1 = prod[61:30];

    // stage 2: quotient estimate
    assign est  = 64'(r_p1) * 64'(RECIP);
    assign n_qe = est[63:32];

    // stage 3: correct estimate, subtract from one
    assign qd  = 32'(r_qe * DIV_W);
    assign rem = r_p2 - qd;
    assign quo = r_qe + ((rem >= DIV_W) ? 32'd1 : 32'd0);
    assign n_t = (quo >= 32'(gbe_pkg::Q30_ONE)) ? 31'd0 : 31'(32'(gbe_pkg::Q30_ONE) - quo);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1  <= n_p1;
            r_x2a <= i_x2;
            r_qe  <= n_qe;
            r_p2  <= r_p1;
            r_x2b <= r_x2a;
            r_t   <= n_t;
            r_x2c <= r_x2b;
        end
    end

    assign o_x2 = r_x2c;
    assign o_t  = r_t;

endmodule

// File: rtl/gbe_div_cell.sv
// Divider cell: one restoring quotient bit per stage.
module gbe_div_cell #(
    parameter int BIT = 0,
    parameter int RW  = 35,
    parameter int DW  = 19,
    parameter int QW  = 15
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [DW-1:0] i_d2,
    input  logic [QW-1:0] i_quo,
    output logic [RW-1:0] o_rem,
    output logic [DW-1:0] o_d2,
    output logic [QW-1:0] o_quo
);

    logic [RW-1:0] sh;
    logic          ge;
    logic [RW-1:0] n_rem;
    logic [QW-1:0] n_quo;
    logic [RW-1:0] r_rem;
    logic [DW-1:0] r_d2;
    logic [QW-1:0] r_quo;

    // trial subtract of the shifted divisor
    assign sh = RW'(i_d2) << BIT;
    assign ge = (i_rem >= sh);

    always_comb begin
        n_rem = ge ? (i_rem - sh) : i_rem;
        n_quo = i_quo;
        n_quo[BIT] = ge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_d2  <= i_d2;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_d2  = r_d2;
    assign o_quo = r_quo;

endmodule

// File: rtl/gbe_skid.sv
// Output stage: result register plus one skid entry; stalls the pipeline when the skid fills.
module gbe_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    input  gbe_pkg::t_out      i_data,
    input  logic               i_ready,
    output logic               o_en,
    output logic               o_valid,
    output gbe_pkg::t_out      o_data
);

    logic          r_ov, r_sv;
    gbe_pkg::t_out r_od, r_sd;

    assign o_en = !r_sv;

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_sv) begin
            if (!r_ov || i_ready) begin
                r_ov <= i_vld;
            end else if (i_vld) begin
                r_sv <= 1'b1;
            end
        end else if (i_ready) begin
            r_ov <= 1'b1;
            r_sv <= 1'b0;
        end
    end

    // words
    always_ff @(posedge i_clk) begin
        if (!r_sv) begin
            if (!r_ov || i_ready) begin
                r_od <= i_data;
            end else begin
                r_sd <= i_data;
            end
        end else if (i_ready) begin
            r_od <= r_sd;
        end
    end

    assign o_valid = r_ov;
    assign o_data  = r_od;

endmodule

// File: rtl/gradient_ray_box_endpoints_core.sv
// Top level: gradient ray / box endpoint pipeline built from Horner and divider cell chains.
//
//  channel  dir  word                                           handshake
//  i_in     in   angle_sixteenths, box_width, box_height        valid/ready
//  o_out    out  start_x, start_y, end_x, end_y, degenerate     valid/ready
//
// One word per cycle sustained while o_out.ready holds. The pipeline depth is set mainly by
// the six-cell cosine Horner chain and the one-bit-per-cell divider chain.
// Reset is synchronous, active low, and clears the valid bits and the output stage flags only.
// A stalled output holds in the result register; the next word lands in the skid entry,
// and only then does i_in.ready drop and the whole pipeline freeze.
module gradient_ray_box_endpoints_core #(
    parameter int FRAC_BITS      = gbe_pkg::FRAC_BITS_DEF,
    parameter int TRIG_FRAC_BITS = gbe_pkg::TRIG_FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    gbe_stream_if.sink    i_in,
    gbe_stream_if.source  o_out
);

    localparam int MW       = TRIG_FRAC_BITS + 2;
    localparam int CW       = 11 + FRAC_BITS;
    localparam int NW       = 12 + MW + FRAC_BITS + 1;
    localparam int DW       = MW + 1;
    localparam int TRIG_SH  = 30 - TRIG_FRAC_BITS;
    localparam int USED_MIN = (1 << TRIG_FRAC_BITS) / 1000000;
    localparam int TLAT     = 3 * gbe_pkg::N_COS;
    localparam int SLAT     = 3 * (gbe_pkg::N_COS - gbe_pkg::N_SIN);
    localparam int LAT      = 5 + TLAT + 6 + CW;

    typedef struct packed {
        logic [10:0] a;
        logic [1:0]  q;
        logic [11:0] w;
        logic [11:0] h;
    } t_s1;

    typedef struct packed {
        logic [30:0] xp;
        logic [21:0] lo;
        logic [1:0]  q;
        logic [11:0] w;
        logic [11:0] h;
    } t_s2;

    typedef struct packed {
        logic [30:0] xp;
        logic [21:0] lo;
        logic [10:0] qe;
        logic [1:0]  q;
        logic [11:0] w;
        logic [11:0] h;
    } t_s3;

    typedef struct packed {
        logic [30:0] x;
        logic [1:0]  q;
        logic [11:0] w;
        logic [11:0] h;
    } t_trig;

    typedef struct packed {
        logic [MW-1:0] s;
        logic [MW-1:0] c;
        logic [1:0]    q;
        logic [11:0]   w;
        logic [11:0]   h;
    } t_g1;

    typedef struct packed {
        logic [MW-1:0] mx;
        logic [MW-1:0] my;
        logic          negx;
        logic          negy;
        logic          xok;
        logic          yok;
        logic [11:0]   w;
        logic [11:0]   h;
    } t_g2;

    typedef struct packed {
        logic             deg;
        logic             bindx;
        logic             negx;
        logic             negy;
        logic [CW-1:0]    limit;
        logic [CW-1:0]    cx;
        logic [CW-1:0]    cy;
    } t_geo;

    typedef struct packed {
        t_geo          geo;
        logic [11:0]   size;
        logic [MW-1:0] num;
        logic [MW-1:0] den;
    } t_g4;

    typedef struct packed {
        t_geo          geo;
        logic [NW-1:0] n;
        logic [DW-1:0] d2;
    } t_g5;

    typedef struct packed {
        t_geo geo;
        logic ovf;
    } t_dside;

    logic          w_en;
    logic [LAT-1:0] r_vld;

    t_s1   r_s1, n_s1;
    t_s2   r_s2;
    t_s3   r_s3;
    t_trig r_s4;
    t_trig r_s5;
    logic [31:0] r_x2;
    t_trig r_tside [0:TLAT-1];
    logic [30:0] r_sdly [0:SLAT-1];
    t_g1   r_g1, n_g1;
    t_g2   r_g2, n_g2;
    t_g2   r_g3;
    logic [12+MW-1:0] r_pw, r_ph;
    t_g4   r_g4, n_g4;
    t_g5   r_g5;
    logic [NW-1:0] r_rem0;
    logic [DW-1:0] r_d20;
    t_dside r_g6;
    t_dside r_dside [0:CW-1];

    logic [12:0] ang;
    logic [21:0] lo_rem;
    logic [32:0] lo_est;
    logic [30:0] x_full;
    logic [61:0] xx;
    logic [61:0] xs;
    logic [31:0] s_rnd, c_rnd;
    logic [12+MW-1:0] sn;

    logic [31:0] w_sx2 [0:gbe_pkg::N_SIN];
    logic [30:0] w_st  [0:gbe_pkg::N_SIN];
    logic [31:0] w_cx2 [0:gbe_pkg::N_COS];
    logic [30:0] w_ct  [0:gbe_pkg::N_COS];
    logic [NW-1:0] w_rem [0:CW];
    logic [DW-1:0] w_d2  [0:CW];
    logic [CW-1:0] w_quo [0:CW];

    logic [CW-1:0] off, offx, offy;
    logic [CW:0]   ex, sx, ey, sy;
    gbe_pkg::t_out w_res;
    t_geo          gf;

    assign i_in.ready = w_en;

    // valid bits travel alongside the words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // stage 1: reduce angle, split quadrant and offset
    always_comb begin
        ang = (i_in.data.angle_sixteenths >= gbe_pkg::FULL_TURN)
            ? (i_in.data.angle_sixteenths - gbe_pkg::FULL_TURN)
            : i_in.data.angle_sixteenths;
        n_s1.w = i_in.data.box_width;
        n_s1.h = i_in.data.box_height;
        priority if (ang >= gbe_pkg::THREE_Q) begin
            n_s1.q = gbe_pkg::QUAD_3;
            n_s1.a = 11'(ang - gbe_pkg::THREE_Q);
        end else if (ang >= gbe_pkg::HALF_TURN) begin
            n_s1.q = gbe_pkg::QUAD_2;
            n_s1.a = 11'(ang - gbe_pkg::HALF_TURN);
        end else if (ang >= gbe_pkg::QUARTER) begin
            n_s1.q = gbe_pkg::QUAD_1;
            n_s1.a = 11'(ang - gbe_pkg::QUARTER);
        end else begin
            n_s1.q = gbe_pkg::QUAD_0;
            n_s1.a = 11'(ang);
        end
    end

    // stages 2..5: offset to Q1.30 radians, then its square
    assign lo_est = 33'(r_s2.lo) * 33'(gbe_pkg::LO_RECIP);
    assign lo_rem = r_s3.lo - 22'(r_s3.qe * gbe_pkg::RAD_DIV_W);
    assign x_full = r_s3.xp + 31'(r_s3.qe)
                  + ((lo_rem >= 22'(gbe_pkg::RAD_DIV_W)) ? 31'd1 : 31'd0);
    assign xx     = 62'(r_s4.x) * 62'(r_s4.x);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1    <= n_s1;
            r_s2.xp <= 31'(r_s1.a * gbe_pkg::PI_QUOT);
            r_s2.lo <= 22'(r_s1.a * gbe_pkg::PI_REM) + 22'(gbe_pkg::RAD_RND);
            r_s2.q  <= r_s1.q;
            r_s2.w  <= r_s1.w;
            r_s2.h  <= r_s1.h;
            r_s3.xp <= r_s2.xp;
            r_s3.lo <= r_s2.lo;
            r_s3.qe <= lo_est[32:22];
            r_s3.q  <= r_s2.q;
            r_s3.w  <= r_s2.w;
            r_s3.h  <= r_s2.h;
            r_s4.x  <= x_full;
            r_s4.q  <= r_s3.q;
            r_s4.w  <= r_s3.w;
            r_s4.h  <= r_s3.h;
            r_s5    <= r_s4;
            r_x2    <= xx[61:30];
        end
    end

    // sine and cosine Horner chains
    assign w_sx2[0] = r_x2;
    assign w_st[0]  = gbe_pkg::Q30_ONE;
    assign w_cx2[0] = r_x2;
    assign w_ct[0]  = gbe_pkg::Q30_ONE;

    for (genvar gi = 0; gi < gbe_pkg::N_SIN; gi++) begin : g_sin
        gbe_horner_cell #(.DIV(gbe_pkg::SIN_DIV[gi])) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x2  (w_sx2[gi]),
            .i_t   (w_st[gi]),
            .o_x2  (w_sx2[gi+1]),
            .o_t   (w_st[gi+1])
        );
    end

    for (genvar gi = 0; gi < gbe_pkg::N_COS; gi++) begin : g_cos
        gbe_horner_cell #(.DIV(gbe_pkg::COS_DIV[gi])) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x2  (w_cx2[gi]),
            .i_t   (w_ct[gi]),
            .o_x2  (w_cx2[gi+1]),
            .o_t   (w_ct[gi+1])
        );
    end

    // side lines matching the chain latencies
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tside[0] <= r_s5;
            for (int i = 1; i < TLAT; i++) begin
                r_tside[i] <= r_tside[i-1];
            end
            r_sdly[0] <= w_st[gbe_pkg::N_SIN];
            for (int i = 1; i < SLAT; i++) begin
                r_sdly[i] <= r_sdly[i-1];
            end
        end
    end

    // G1: final sine multiply, round both to trig precision
    always_comb begin
        xs      = 62'(r_tside[TLAT-1].x) * 62'(r_sdly[SLAT-1]);
        s_rnd   = {1'b0, xs[60:30]} + (32'd1 << (TRIG_SH - 1));
        c_rnd   = {1'b0, w_ct[gbe_pkg::N_COS]} + (32'd1 << (TRIG_SH - 1));
        n_g1.s  = MW'(s_rnd >> TRIG_SH);
        n_g1.c  = MW'(c_rnd >> TRIG_SH);
        n_g1.q  = r_tside[TLAT-1].q;
        n_g1.w  = r_tside[TLAT-1].w;
        n_g1.h  = r_tside[TLAT-1].h;
    end

    // G2: quadrant mapping, dx = sin, dy = -cos
    always_comb begin
        n_g2.w = r_g1.w;
        n_g2.h = r_g1.h;
        unique case (r_g1.q)
            gbe_pkg::QUAD_0: begin
                n_g2.mx = r_g1.s; n_g2.negx = 1'b0; n_g2.my = r_g1.c; n_g2.negy = 1'b1;
            end
            gbe_pkg::QUAD_1: begin
                n_g2.mx = r_g1.c; n_g2.negx = 1'b0; n_g2.my = r_g1.s; n_g2.negy = 1'b0;
            end
            gbe_pkg::QUAD_2: begin
                n_g2.mx = r_g1.s; n_g2.negx = 1'b1; n_g2.my = r_g1.c; n_g2.negy = 1'b0;
            end
            default: begin
                n_g2.mx = r_g1.c; n_g2.negx = 1'b1; n_g2.my = r_g1.s; n_g2.negy = 1'b1;
            end
        endcase
        n_g2.xok = (n_g2.mx > MW'(USED_MIN)) && (r_g1.w != 12'd0);
        n_g2.yok = (n_g2.my > MW'(USED_MIN)) && (r_g1.h != 12'd0);
    end

    // G4: pick binding axis and division operands
    always_comb begin
        n_g4.geo.deg   = !r_g3.xok && !r_g3.yok;
        n_g4.geo.bindx = r_g3.xok && (!r_g3.yok || (r_pw <= r_ph));
        n_g4.geo.negx  = r_g3.negx;
        n_g4.geo.negy  = r_g3.negy;
        n_g4.geo.cx    = CW'(r_g3.w) << (FRAC_BITS - 1);
        n_g4.geo.cy    = CW'(r_g3.h) << (FRAC_BITS - 1);
        if (n_g4.geo.bindx) begin
            n_g4.size      = r_g3.w;
            n_g4.num       = r_g3.my;
            n_g4.den       = r_g3.mx;
            n_g4.geo.limit = n_g4.geo.cy;
        end else begin
            n_g4.size      = r_g3.h;
            n_g4.num       = r_g3.mx;
            n_g4.den       = r_g3.my;
            n_g4.geo.limit = n_g4.geo.cx;
        end
    end

    assign sn = (12+MW)'(r_g4.size * r_g4.num);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g1     <= n_g1;
            r_g2     <= n_g2;
            r_g3     <= r_g2;
            r_pw     <= (12+MW)'(r_g2.w * r_g2.my);
            r_ph     <= (12+MW)'(r_g2.h * r_g2.mx);
            r_g4     <= n_g4;
            r_g5.geo <= r_g4.geo;
            r_g5.n   <= (NW'(sn) << FRAC_BITS) + NW'(r_g4.den);
            r_g5.d2  <= DW'(r_g4.den) << 1;
            r_g6.geo <= r_g5.geo;
            r_g6.ovf <= (r_g5.n >= (NW'(r_g5.d2) << CW));
            r_rem0   <= r_g5.n;
            r_d20    <= r_g5.d2;
        end
    end

    // divider chain, most significant quotient bit first
    assign w_rem[0] = r_rem0;
    assign w_d2[0]  = r_d20;
    assign w_quo[0] = '0;

    for (genvar gi = 0; gi < CW; gi++) begin : g_div
        gbe_div_cell #(.BIT(CW-1-gi), .RW(NW), .DW(DW), .QW(CW)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_rem (w_rem[gi]),
            .i_d2  (w_d2[gi]),
            .i_quo (w_quo[gi]),
            .o_rem (w_rem[gi+1]),
            .o_d2  (w_d2[gi+1]),
            .o_quo (w_quo[gi+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dside[0] <= r_g6;
            for (int i = 1; i < CW; i++) begin
                r_dside[i] <= r_dside[i-1];
            end
        end
    end

    // G7: clamp offset, form endpoints
    always_comb begin
        gf  = r_dside[CW-1].geo;
        off = (r_dside[CW-1].ovf || (w_quo[CW] > gf.limit)) ? gf.limit : w_quo[CW];
        if (gf.deg) begin
            offx = '0;
            offy = '0;
        end else if (gf.bindx) begin
            offx = gf.cx;
            offy = off;
        end else begin
            offx = off;
            offy = gf.cy;
        end
        ex = gf.negx ? ({1'b0, gf.cx} - {1'b0, offx}) : ({1'b0, gf.cx} + {1'b0, offx});
        sx = gf.negx ? ({1'b0, gf.cx} + {1'b0, offx}) : ({1'b0, gf.cx} - {1'b0, offx});
        ey = gf.negy ? ({1'b0, gf.cy} - {1'b0, offy}) : ({1'b0, gf.cy} + {1'b0, offy});
        sy = gf.negy ? ({1'b0, gf.cy} + {1'b0, offy}) : ({1'b0, gf.cy} - {1'b0, offy});
        w_res.start_x    = 16'(sx);
        w_res.start_y    = 16'(sy);
        w_res.end_x      = 16'(ex);
        w_res.end_y      = 16'(ey);
        w_res.degenerate = gf.deg;
    end

    // output register and skid entry
    gbe_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[LAT-1]),
        .i_data  (w_res),
        .i_ready (o_out.ready),
        .o_en    (w_en),
        .o_valid (o_out.valid),
        .o_data  (o_out.data)
    );

endmodule
